>>> rtl/sgcp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgcp_pkg
// Shared types and codes of the serial gain command parser: the item structs,
// the command-mode codes and the character codes that the parser reacts to.
// ----------------------------------------------------------------------------
package sgcp_pkg;

  localparam int GAIN_WIDTH_DEF = 16;
  localparam int DUTY_WIDTH_DEF = 16;

  localparam int MODE_W = 4;

  // Command-mode codes.
  localparam logic [MODE_W-1:0] M_IDLE   = 4'd0;
  localparam logic [MODE_W-1:0] M_AFTER0 = 4'd1;
  localparam logic [MODE_W-1:0] M_AFTER9 = 4'd2;
  localparam logic [MODE_W-1:0] M_STOP0  = 4'd3;
  localparam logic [MODE_W-1:0] M_STOP1  = 4'd4;
  localparam logic [MODE_W-1:0] M_RESUME = 4'd5;
  localparam logic [MODE_W-1:0] M_GSEL   = 4'd6;
  localparam logic [MODE_W-1:0] M_CODE3  = 4'd7;
  localparam logic [MODE_W-1:0] M_PENT   = 4'd8;
  localparam logic [MODE_W-1:0] M_IENT   = 4'd9;
  localparam logic [MODE_W-1:0] M_DENT   = 4'd10;

  // Character codes.
  localparam logic [7:0] CHR_A  = 8'h41;
  localparam logic [7:0] CHR_CR = 8'h0D;
  localparam logic [7:0] CHR_0  = 8'h30;
  localparam logic [7:0] CHR_9  = 8'h39;
  localparam logic [7:0] CHR_P  = 8'h50;
  localparam logic [7:0] CHR_I  = 8'h49;
  localparam logic [7:0] CHR_D  = 8'h44;

  // Digit values that carry a command meaning.
  localparam logic [3:0] DIG_0 = 4'd0;
  localparam logic [3:0] DIG_1 = 4'd1;
  localparam logic [3:0] DIG_2 = 4'd2;
  localparam logic [3:0] DIG_3 = 4'd3;
  localparam logic [3:0] DIG_9 = 4'd9;

  typedef struct packed {
    logic [7:0]  rx_char;
    logic [15:0] motor_duty;
  } in_item_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [15:0]       gain_p;
    logic [15:0]       gain_i;
    logic [15:0]       gain_d;
    logic              ready_flag;
    logic              duty_write;
    logic [15:0]       duty_value;
  } out_item_t;

endpackage

>>> rtl/serial_gain_command_parser_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_gain_command_parser_unit
// Command parser for received serial characters: stop/resume of the motor
// duty, decimal entry of the P, I and D gains, and a ready flag.
//
//   Channel   Direction  Handshake          Payload
//   in_*      input      in_valid/in_ready  in_item_t  (rx_char, motor_duty)
//   out_*     output     out_valid/out_ready out_item_t (mode, gains, flags)
//
// One item is taken per cycle while in_ready is high; its result is registered
// in the output register. The parser state updates in the accepting cycle.
// A skid register holds one extra result, so an item is still taken while
// the output register waits; in_ready drops only when both are full.
// Reset (rst_n low, synchronous) returns to idle with gains, flag and saved
// duty cleared.
// ----------------------------------------------------------------------------
module serial_gain_command_parser_unit #(
  parameter int GAIN_WIDTH = sgcp_pkg::GAIN_WIDTH_DEF,
  parameter int DUTY_WIDTH = sgcp_pkg::DUTY_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  sgcp_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output sgcp_pkg::out_item_t out_data
);
  import sgcp_pkg::*;

  logic [MODE_W-1:0]     mode_r, mode_nxt;
  logic [GAIN_WIDTH-1:0] gain_p_r, gain_p_nxt;
  logic [GAIN_WIDTH-1:0] gain_i_r, gain_i_nxt;
  logic [GAIN_WIDTH-1:0] gain_d_r, gain_d_nxt;
  logic                  ready_r, ready_nxt;
  logic [DUTY_WIDTH-1:0] saved_duty_r, saved_duty_nxt;

  logic                  out_valid_r;
  out_item_t             out_data_r;
  logic                  skid_valid_r;
  out_item_t             skid_data_r;

  logic                  acc_in;
  logic                  acc_out;
  logic [7:0]            c;
  logic [3:0]            d;
  logic                  is_digit;
  logic [DUTY_WIDTH-1:0] duty_in;
  logic [GAIN_WIDTH-1:0] gain_sel;
  logic [GAIN_WIDTH-1:0] gain_acc;
  logic                  dw;
  logic [DUTY_WIDTH-1:0] dv;
  out_item_t             res;

  assign in_ready = !skid_valid_r;
  assign acc_in   = in_valid && in_ready;
  assign acc_out  = out_valid_r && out_ready;

  assign c        = in_data.rx_char;
  assign d        = 4'(c - CHR_0);
  assign is_digit = (c inside {[CHR_0:CHR_9]});
  assign duty_in  = DUTY_WIDTH'(in_data.motor_duty);

  // Gain of the current entry mode, times ten plus the digit.
  always_comb begin
    case (mode_r)
      M_PENT:  gain_sel = gain_p_r;
      M_IENT:  gain_sel = gain_i_r;
      default: gain_sel = gain_d_r;
    endcase
  end
  assign gain_acc = (gain_sel << 3) + (gain_sel << 1) + GAIN_WIDTH'(d);

  always_comb begin
    mode_nxt       = mode_r;
    gain_p_nxt     = gain_p_r;
    gain_i_nxt     = gain_i_r;
    gain_d_nxt     = gain_d_r;
    ready_nxt      = ready_r;
    saved_duty_nxt = saved_duty_r;
    dw             = 1'b0;
    dv             = '0;
    if (c == CHR_A) begin
      mode_nxt   = M_IDLE;
      gain_p_nxt = '0;
      gain_i_nxt = '0;
      gain_d_nxt = '0;
    end else if (c == CHR_CR) begin
      ready_nxt = !ready_r;
    end else if (is_digit) begin
      if (mode_r == M_AFTER9 && (d == DIG_0 || d == DIG_1)) begin
        mode_nxt       = (d == DIG_0) ? M_STOP0 : M_STOP1;
        saved_duty_nxt = duty_in;
        dw             = 1'b1;
        ready_nxt      = (d == DIG_1);
      end else if (mode_r == M_IDLE && d == DIG_0) begin
        mode_nxt = M_AFTER0;
      end else if (mode_r == M_IDLE && d == DIG_9) begin
        mode_nxt = M_AFTER9;
      end else if (mode_r == M_AFTER0 && d == DIG_1) begin
        mode_nxt  = M_RESUME;
        dw        = 1'b1;
        dv        = saved_duty_r;
        ready_nxt = 1'b1;
      end else if (mode_r == M_AFTER0 && d == DIG_2) begin
        mode_nxt = M_GSEL;
      end else if (mode_r == M_AFTER0 && d == DIG_3) begin
        mode_nxt = M_CODE3;
      end else if (mode_r == M_PENT) begin
        gain_p_nxt = gain_acc;
      end else if (mode_r == M_IENT) begin
        gain_i_nxt = gain_acc;
      end else if (mode_r == M_DENT) begin
        gain_d_nxt = gain_acc;
      end
    end else if (mode_r == M_GSEL) begin
      if (c == CHR_P) begin
        mode_nxt = M_PENT;
      end else if (c == CHR_I) begin
        mode_nxt = M_IENT;
      end else if (c == CHR_D) begin
        mode_nxt = M_DENT;
      end
    end
  end

  always_comb begin
    res.mode       = mode_nxt;
    res.gain_p     = 16'(gain_p_nxt);
    res.gain_i     = 16'(gain_i_nxt);
    res.gain_d     = 16'(gain_d_nxt);
    res.ready_flag = ready_nxt;
    res.duty_write = dw;
    res.duty_value = 16'(dv);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= M_IDLE;
      gain_p_r     <= '0;
      gain_i_r     <= '0;
      gain_d_r     <= '0;
      ready_r      <= 1'b0;
      saved_duty_r <= '0;
    end else if (acc_in) begin
      mode_r       <= mode_nxt;
      gain_p_r     <= gain_p_nxt;
      gain_i_r     <= gain_i_nxt;
      gain_d_r     <= gain_d_nxt;
      ready_r      <= ready_nxt;
      saved_duty_r <= saved_duty_nxt;
    end
  end

  // Output register with one skid entry behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (acc_out) begin
        skid_valid_r <= 1'b0;
      end
    end else if (acc_in) begin
      if (out_valid_r && !out_ready) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (acc_out) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (acc_out) begin
        out_data_r <= skid_data_r;
      end
    end else if (acc_in) begin
      if (out_valid_r && !out_ready) begin
        skid_data_r <= res;
      end else begin
        out_data_r <= res;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> rtl/sgcp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgcp_checker
// Port-level checks of the serial gain command parser, bound to the parser
// unit.
// ----------------------------------------------------------------------------
module sgcp_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input sgcp_pkg::out_item_t out_data
);
  import sgcp_pkg::*;

  // A stalled result item holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result item changed while stalled");

  // Only the stop and resume commands drive a duty.
  a_dw_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.duty_write |->
      (out_data.mode == M_STOP0 || out_data.mode == M_STOP1 ||
       out_data.mode == M_RESUME))
    else $error("duty write outside a stop or resume command");

  // Stop commands apply zero duty; no duty is shown without a write.
  a_dv_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (!out_data.duty_write || out_data.mode != M_RESUME) |->
      out_data.duty_value == 16'd0)
    else $error("nonzero duty value outside a resume command");

  // The ready flag follows the command that wrote the duty.
  a_dw_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.duty_write |->
      out_data.ready_flag == (out_data.mode != M_STOP0))
    else $error("ready flag does not match stop or resume command");

  // The mode never leaves the defined codes.
  a_mode_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.mode <= M_DENT)
    else $error("undefined mode code on the result");

endmodule

bind serial_gain_command_parser_unit sgcp_checker u_sgcp_checker (.*);

>>> dv/tb_serial_gain_command_parser_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_serial_gain_command_parser_unit
// Self-checking bench for the serial gain command parser. The bench starts
// with a directed character string, then mostly well-formed command
// sequences with random content, mixed with noise and broken sequences.
// Every accepted item is run through a local model of the command machine.
// Each result is compared field by field with the oldest predicted status.
// The run has four phases with different idle and stall rates on both sides.
// ----------------------------------------------------------------------------
module tb_serial_gain_command_parser_unit;
  import sgcp_pkg::*;

  localparam int ITEMS_PER_PHASE = 425;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int MAX_REPORTS     = 10;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  serial_gain_command_parser_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Characters waiting to be sent and parser status words waiting to come out.
  in_item_t  char_fifo[$];
  out_item_t status_fifo[$];

  int idle_pct;
  int stall_pct;
  int errors;
  int chars_accepted;
  int status_checked;
  int duty_cmds;
  int gain_digits;
  int cycles;

  // Local copy of the command machine.
  logic [MODE_W-1:0] cmd_mode;
  logic [15:0]       p_gain;
  logic [15:0]       i_gain;
  logic [15:0]       d_gain;
  logic              ok_flag;
  logic [15:0]       held_duty;

  always #5 clk = ~clk;

  function automatic logic [7:0] digit_char(logic [3:0] d);
    return 8'(CHR_0 + d);
  endfunction

  function automatic logic [15:0] rnd_duty();
    return 16'($urandom_range(65535));
  endfunction

  function automatic string fmt_status(out_item_t s);
    return $sformatf("mode=%0d p=%0d i=%0d d=%0d rdy=%0b dw=%0b dv=%0d",
                     s.mode, s.gain_p, s.gain_i, s.gain_d, s.ready_flag,
                     s.duty_write, s.duty_value);
  endfunction

  // Advances the local machine by one character and queues the status it causes.
  task automatic apply_char(in_item_t it);
    logic [7:0] c;
    logic [3:0] d;
    logic       taken;
    out_item_t  r;
    c = it.rx_char;
    r = '0;
    if (c == CHR_A) begin
      cmd_mode = M_IDLE;
      p_gain   = '0;
      i_gain   = '0;
      d_gain   = '0;
    end else if (c == CHR_CR) begin
      ok_flag = ~ok_flag;
    end else if (c >= CHR_0 && c <= CHR_9) begin
      d = 4'(c - CHR_0);
      taken = 1'b1;
      if (cmd_mode == M_AFTER9 && (d == DIG_0 || d == DIG_1)) begin
        cmd_mode     = (d == DIG_0) ? M_STOP0 : M_STOP1;
        held_duty    = it.motor_duty;
        r.duty_write = 1'b1;
        r.duty_value = '0;
        ok_flag      = (d == DIG_1);
        duty_cmds++;
      end else if (cmd_mode == M_IDLE && d == DIG_0) begin
        cmd_mode = M_AFTER0;
      end else if (cmd_mode == M_IDLE && d == DIG_9) begin
        cmd_mode = M_AFTER9;
      end else if (cmd_mode == M_AFTER0 && d == DIG_1) begin
        // A resume before any stop applies the cleared saved duty.
        cmd_mode     = M_RESUME;
        r.duty_write = 1'b1;
        r.duty_value = held_duty;
        ok_flag      = 1'b1;
        duty_cmds++;
      end else if (cmd_mode == M_AFTER0 && d == DIG_2) begin
        cmd_mode = M_GSEL;
      end else if (cmd_mode == M_AFTER0 && d == DIG_3) begin
        cmd_mode = M_CODE3;
      end else begin
        taken = 1'b0;
      end
      if (!taken) begin
        // The gains wrap at 16 bits through the width of the assignment.
        case (cmd_mode)
          M_PENT: begin
            p_gain = p_gain * 16'd10 + 16'(d);
            gain_digits++;
          end
          M_IENT: begin
            i_gain = i_gain * 16'd10 + 16'(d);
            gain_digits++;
          end
          M_DENT: begin
            d_gain = d_gain * 16'd10 + 16'(d);
            gain_digits++;
          end
          default: ;
        endcase
      end
    end else if (cmd_mode == M_GSEL) begin
      if (c == CHR_P) cmd_mode = M_PENT;
      else if (c == CHR_I) cmd_mode = M_IENT;
      else if (c == CHR_D) cmd_mode = M_DENT;
    end
    r.mode       = cmd_mode;
    r.gain_p     = p_gain;
    r.gain_i     = i_gain;
    r.gain_d     = d_gain;
    r.ready_flag = ok_flag;
    status_fifo.push_back(r);
  endtask

  task automatic push_char(logic [7:0] c, logic [15:0] duty);
    in_item_t it;
    it.rx_char    = c;
    it.motor_duty = duty;
    char_fifo.push_back(it);
  endtask

  task automatic push_directed();
    int k;
    push_char(CHR_CR, 16'h0000);
    push_char(digit_char(DIG_0), 16'h0000);
    push_char(digit_char(DIG_1), 16'h0000);  // resume before any stop
    push_char(CHR_A, 16'h0000);
    push_char(digit_char(DIG_9), 16'h0000);
    push_char(digit_char(DIG_0), 16'hFFFF);  // stop with ready cleared
    push_char(CHR_CR, 16'h0000);             // toggle inside a dead-end mode
    push_char(digit_char(4'd5), 16'h0000);
    push_char(CHR_A, 16'h0000);
    push_char(digit_char(DIG_0), 16'h0000);
    push_char(digit_char(DIG_1), 16'h0000);  // restores the saved full-scale duty
    push_char(CHR_A, 16'h0000);
    push_char(digit_char(DIG_9), 16'h0000);
    push_char(digit_char(DIG_1), 16'h0000);  // stop with ready set, saves zero
    push_char(CHR_A, 16'h0000);
    push_char(digit_char(DIG_0), 16'h0000);
    push_char(digit_char(DIG_3), 16'h0000);
    push_char(CHR_A, 16'h0000);
    push_char(digit_char(DIG_0), 16'h0000);
    push_char(digit_char(DIG_2), 16'h0000);
    push_char(8'hFF, 16'hFFFF);              // high codes never match
    push_char(CHR_P, 16'h0000);
    for (k = 0; k < 5; k++) push_char(digit_char(DIG_9), 16'h0000);  // wraps
    push_char(8'h80, 16'h0000);
  endtask

  task automatic push_gain_select();
    case ($urandom_range(2))
      0:       push_char(CHR_P, rnd_duty());
      1:       push_char(CHR_I, rnd_duty());
      default: push_char(CHR_D, rnd_duty());
    endcase
  endtask

  task automatic push_random_sequence();
    int k;
    int n;
    case ($urandom_range(9))
      0, 1, 2, 9: begin
        // Gain entry; without the leading reset it may start in any mode.
        if ($urandom_range(9) != 9) push_char(CHR_A, rnd_duty());
        push_char(digit_char(DIG_0), rnd_duty());
        push_char(digit_char(DIG_2), rnd_duty());
        push_gain_select();
        n = $urandom_range(8, 1);
        for (k = 0; k < n; k++) begin
          if ($urandom_range(15) == 0) push_char(CHR_CR, rnd_duty());
          push_char(digit_char(4'($urandom_range(9))), rnd_duty());
        end
      end
      3: begin
        push_char(CHR_A, rnd_duty());
        push_char(digit_char(DIG_9), rnd_duty());
        push_char(digit_char(4'($urandom_range(1))), rnd_duty());
      end
      4: begin
        push_char(CHR_A, rnd_duty());
        push_char(digit_char(DIG_0), rnd_duty());
        push_char(digit_char(DIG_1), rnd_duty());
      end
      5: begin
        push_char(CHR_A, rnd_duty());
        push_char(digit_char(DIG_0), rnd_duty());
        push_char(digit_char(DIG_3), rnd_duty());
        n = $urandom_range(3);
        for (k = 0; k < n; k++) push_char(8'($urandom_range(255)), rnd_duty());
      end
      6: push_char(CHR_CR, rnd_duty());
      7: begin
        n = $urandom_range(4, 1);
        for (k = 0; k < n; k++) push_char(8'($urandom_range(255)), rnd_duty());
      end
      default: begin
        // A valid prefix followed by a random character, which may break the command or complete it.
        push_char(CHR_A, rnd_duty());
        push_char($urandom_range(1) ? digit_char(DIG_0) : digit_char(DIG_9), rnd_duty());
        case ($urandom_range(3))
          0:       push_char(digit_char(4'($urandom_range(9))), rnd_duty());
          1:       push_gain_select();
          2:       push_char(8'($urandom_range(255)), rnd_duty());
          default: push_char(digit_char(DIG_2), rnd_duty());
        endcase
      end
    endcase
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (char_fifo.size() != 0 || in_valid || status_fifo.size() != 0);
  endtask

  // Driver: predicts each accepted item and presents the next one.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        apply_char(in_data);
        chars_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (char_fifo.size() != 0 && $urandom_range(99) >= idle_pct) begin
          in_data  <= char_fifo.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver back-pressure.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Monitor: compares every accepted result with the oldest prediction.
  always @(posedge clk) begin : monitor
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (status_fifo.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("unexpected result with nothing pending: %s", fmt_status(out_data));
      end else begin
        want = status_fifo.pop_front();
        status_checked++;
        if (want.mode !== out_data.mode || want.gain_p !== out_data.gain_p ||
            want.gain_i !== out_data.gain_i || want.gain_d !== out_data.gain_d ||
            want.ready_flag !== out_data.ready_flag ||
            want.duty_write !== out_data.duty_write ||
            want.duty_value !== out_data.duty_value) begin
          errors++;
          if (errors <= MAX_REPORTS) begin
            $display("mismatch at result %0d", status_checked);
            $display("  expected %s", fmt_status(want));
            $display("  actual   %s", fmt_status(out_data));
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending", cycles,
               status_fifo.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int phase;
    int target;
    clk            = 1'b0;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    out_ready      = 1'b0;
    idle_pct       = 0;
    stall_pct      = 0;
    errors         = 0;
    chars_accepted = 0;
    status_checked = 0;
    duty_cmds      = 0;
    gain_digits    = 0;
    cycles         = 0;
    cmd_mode       = M_IDLE;
    p_gain         = '0;
    i_gain         = '0;
    d_gain         = '0;
    ok_flag        = 1'b0;
    held_duty      = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 87; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 87; end
        default: begin idle_pct = 25; stall_pct = 25; end
      endcase
      if (phase == 0) push_directed();
      target = char_fifo.size() + ITEMS_PER_PHASE;
      while (char_fifo.size() < target) push_random_sequence();
      wait_drained();
    end
    repeat (20) @(negedge clk);
    $display("%0d characters parsed in four pacing phases, %0d status words checked",
             chars_accepted, status_checked);
    $display("%0d stop/resume duty commands and %0d gain digits seen, %0d errors",
             duty_cmds, gain_digits, errors);
    if (errors == 0 && status_fifo.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
